### hdl/lmjcd_pkg.sv
package lmjcd_pkg;

  localparam int CLASS_W = 2;
  localparam int REG_W = 7;
  localparam int PC_W = 64;
  localparam int CNT_W = 64;
  localparam int GAP_W = 4;

  localparam logic [CLASS_W-1:0] CLS_OTHER = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_LOAD = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_EXP = 2'd2;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 4'd4;
  localparam logic [REG_W-1:0] REG_NONE = 7'h7F;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic hash1;
    logic hash2;
    logic commit;
  } lmjcd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_go;
    logic hit;
    logic last_li;
    logic out_free;
  } lmjcd_sts_t;

endpackage

### hdl/lmjcd_ifs.sv
interface lmjcd_in_if
  import lmjcd_pkg::*;
;
  logic valid;
  logic ready;
  logic new_block;
  logic [CLASS_W-1:0] instr_class;
  logic signed [REG_W-1:0] dst_reg;
  logic signed [REG_W-1:0] src_a;
  logic signed [REG_W-1:0] src_b;
  logic [PC_W-1:0] instr_pc;

  modport source (output valid, new_block, instr_class, dst_reg, src_a, src_b, instr_pc,
                  input ready);
  modport sink (input valid, new_block, instr_class, dst_reg, src_a, src_b, instr_pc,
                output ready);
endinterface

interface lmjcd_out_if
  import lmjcd_pkg::*;
;
  logic valid;
  logic ready;
  logic chain_found;
  logic [PC_W-1:0] load_pc;
  logic [PC_W-1:0] expensive_pc;
  logic signed [REG_W-1:0] load_reg;
  logic signed [REG_W-1:0] expensive_reg;
  logic [PC_W-1:0] chain_key;
  logic [CNT_W-1:0] count_all;
  logic [CNT_W-1:0] count_load;
  logic [CNT_W-1:0] count_expensive;

  modport source (output valid, chain_found, load_pc, expensive_pc, load_reg, expensive_reg,
                  chain_key, count_all, count_load, count_expensive, input ready);
  modport sink (input valid, chain_found, load_pc, expensive_pc, load_reg, expensive_reg,
                chain_key, count_all, count_load, count_expensive, output ready);
endinterface

### hdl/lmjcd_ctrl.sv
module lmjcd_ctrl
  import lmjcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lmjcd_sts_t sts,
  output lmjcd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HASH1 = 3'd2;
  localparam logic [2:0] S_HASH2 = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Sequence one item: capture, scan load candidates, hash, commit
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.search_go) begin
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.hit) state_next = S_HASH1;
          else if (sts.last_li) state_next = S_FINISH;
        end
      end
      S_HASH1: begin
        cmd.hash1 = 1'b1;
        state_next = S_HASH2;
      end
      S_HASH2: begin
        cmd.hash2 = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_SCAN)
    else $error("capture did not start a scan");
  a_hash_order: assert property (@(posedge clk) disable iff (rst)
    cmd.hash2 |-> $past(cmd.hash1))
    else $error("second hash step without first");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("not ready after commit");

endmodule

### hdl/lmjcd_dpath.sv
module lmjcd_dpath
  import lmjcd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata,
  lmjcd_in_if.sink   in_ch,
  lmjcd_out_if.source out_ch,
  input  lmjcd_cmd_t cmd,
  output lmjcd_sts_t sts
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int GW = (IDX_W > GAP_W) ? IDX_W : GAP_W;

  logic [GAP_W-1:0] max_gap;

  logic [CLASS_W-1:0] win_class [WINDOW_DEPTH];
  logic [REG_W-1:0] win_dest [WINDOW_DEPTH];
  logic [REG_W-1:0] win_src_a [WINDOW_DEPTH];
  logic [REG_W-1:0] win_src_b [WINDOW_DEPTH];
  logic [PC_W-1:0] win_pc [WINDOW_DEPTH];
  logic [FW-1:0] fill;

  logic [CLASS_W-1:0] j_class;
  logic [REG_W-1:0] j_dest;
  logic [REG_W-1:0] j_sa;
  logic [REG_W-1:0] j_sb;
  logic [PC_W-1:0] j_pc;

  logic [CNT_W-1:0] total_seen;
  logic [CNT_W-1:0] total_loads;
  logic [CNT_W-1:0] exp_total;

  logic [IDX_W-1:0] li;
  logic found;
  logic [PC_W-1:0] l_pc;
  logic [PC_W-1:0] e_pc;
  logic [REG_W-1:0] l_reg;
  logic [REG_W-1:0] e_reg;
  logic [PC_W-1:0] key;

  logic [WINDOW_DEPTH-1:0] pair;
  logic [IDX_W-1:0] fe;
  logic out_valid;

  // Hold the gap limit
  always_ff @(posedge clk) begin
    if (rst) max_gap <= MAX_GAP_RESET;
    else if (cfg_we) max_gap <= cfg_wdata;
  end

  // Test every expensive candidate against the load at li in parallel
  always_comb begin
    logic [REG_W-1:0] rl;
    logic [REG_W-1:0] re;
    logic [IDX_W-1:0] ev;
    logic [IDX_W-1:0] gap;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] iv;
    logic ok;
    logic hit_i;
    logic rd_first;
    logic rd_second;
    rl = win_dest[li];
    for (int e = 0; e < WINDOW_DEPTH; e++) begin
      ev = IDX_W'(unsigned'(e));
      re = win_dest[e];
      gap = (li > ev) ? li - ev : ev - li;
      first = (li < ev) ? li : ev;
      second = (li < ev) ? ev : li;
      ok = (FW'(ev) < fill) && (ev != li) && (win_class[e] == CLS_EXP)
           && !rl[REG_W-1] && !re[REG_W-1] && (rl != re)
           && (GW'(gap) <= GW'(max_gap))
           && ((j_sa == rl) || (j_sb == rl)) && ((j_sa == re) || (j_sb == re));
      if (ev > li && ((win_src_a[e] == rl) || (win_src_b[e] == rl))) ok = 1'b0;
      if (li > ev && (win_src_a[li] == re)) ok = 1'b0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        iv = IDX_W'(unsigned'(i));
        hit_i = (win_dest[i] == rl) || (win_dest[i] == re);
        rd_first = (win_src_a[i] == win_dest[first]) || (win_src_b[i] == win_dest[first]);
        rd_second = (win_src_a[second] == win_dest[i]) || (win_src_b[second] == win_dest[i]);
        if (iv > first && iv < second) begin
          if (hit_i) ok = 1'b0;
          if (!win_dest[first][REG_W-1] && rd_first && !win_dest[i][REG_W-1] && rd_second)
            ok = 1'b0;
        end
        if (iv > second && FW'(iv) < fill && hit_i) ok = 1'b0;
      end
      pair[e] = ok;
    end
  end

  // Pick the first expensive candidate
  always_comb begin
    fe = '0;
    for (int e = WINDOW_DEPTH - 1; e >= 0; e--) begin
      if (pair[e]) fe = IDX_W'(unsigned'(e));
    end
  end

  assign sts.search_go = !j_sa[REG_W-1] && !j_sb[REG_W-1] && (fill != '0);
  assign sts.hit = (win_class[li] == CLS_LOAD) && (|pair);
  assign sts.last_li = (FW'(li) + FW'(1)) == fill;
  assign sts.out_free = !out_valid || out_ch.ready;

  // Capture the item, advance counters, scan and hash
  always_ff @(posedge clk) begin
    if (rst) begin
      total_seen <= '0;
      total_loads <= '0;
      exp_total <= '0;
      fill <= '0;
      found <= 1'b0;
      li <= '0;
    end else begin
      if (cmd.capture) begin
        j_class <= in_ch.instr_class;
        j_dest <= in_ch.dst_reg;
        j_sa <= in_ch.src_a;
        j_sb <= in_ch.src_b;
        j_pc <= in_ch.instr_pc;
        total_seen <= total_seen + CNT_W'(1);
        if (in_ch.instr_class == CLS_LOAD) total_loads <= total_loads + CNT_W'(1);
        if (in_ch.instr_class == CLS_EXP) exp_total <= exp_total + CNT_W'(1);
        if (in_ch.new_block) fill <= '0;
        found <= 1'b0;
        li <= '0;
      end
      if (cmd.scan_step) begin
        li <= li + IDX_W'(1);
        if (sts.hit) begin
          found <= 1'b1;
          l_pc <= win_pc[li];
          l_reg <= win_dest[li];
          e_pc <= win_pc[fe];
          e_reg <= win_dest[fe];
        end
      end
      if (cmd.commit) begin
        if (fill < FW'(WINDOW_DEPTH)) fill <= fill + FW'(1);
      end
    end
  end

  // Two-step chain key
  always_ff @(posedge clk) begin
    if (cmd.hash1) key <= l_pc ^ (e_pc + (l_pc << 6) + (l_pc >> 2));
    if (cmd.hash2) key <= key ^ (j_pc + (key << 6) + (key >> 2));
  end

  // Append the joined item to the window, shifting out the oldest when full
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (fill < FW'(WINDOW_DEPTH)) begin
        win_class[fill[IDX_W-1:0]] <= j_class;
        win_dest[fill[IDX_W-1:0]] <= j_dest;
        win_src_a[fill[IDX_W-1:0]] <= j_sa;
        win_src_b[fill[IDX_W-1:0]] <= j_sb;
        win_pc[fill[IDX_W-1:0]] <= j_pc;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          win_class[i] <= win_class[i+1];
          win_dest[i] <= win_dest[i+1];
          win_src_a[i] <= win_src_a[i+1];
          win_src_b[i] <= win_src_b[i+1];
          win_pc[i] <= win_pc[i+1];
        end
        win_class[WINDOW_DEPTH-1] <= j_class;
        win_dest[WINDOW_DEPTH-1] <= j_dest;
        win_src_a[WINDOW_DEPTH-1] <= j_sa;
        win_src_b[WINDOW_DEPTH-1] <= j_sb;
        win_pc[WINDOW_DEPTH-1] <= j_pc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ch.chain_found <= found;
      out_ch.load_pc <= found ? l_pc : '0;
      out_ch.expensive_pc <= found ? e_pc : '0;
      out_ch.load_reg <= found ? l_reg : REG_NONE;
      out_ch.expensive_reg <= found ? e_reg : REG_NONE;
      out_ch.chain_key <= !found ? '0 : ((key == '0) ? PC_W'(1) : key);
      out_ch.count_all <= total_seen;
      out_ch.count_load <= total_loads;
      out_ch.count_expensive <= exp_total;
    end
  end

  assign out_ch.valid = out_valid;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH))
    else $error("window fill beyond depth");
  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> FW'(li) < fill)
    else $error("scan past window fill");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");
  a_hit_distinct: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && sts.hit) |=> (l_reg != e_reg))
    else $error("matched producers write the same register");

endmodule

### hdl/load_mul_join_chain_detector.sv
// Load / expensive-op join detector. Each instruction item is compared with a
// window of the last WINDOW_DEPTH instructions; when it reads both a load
// result and a mul/div result that are independent and not overwritten, the
// first such pair (load index outer, expensive index inner, window order) is
// reported with a 64-bit chain key, together with three wrapping counters.
// With no search an item goes from capture straight to commit; otherwise the
// scan tries window slots in turn as load (up to WINDOW_DEPTH), and a match
// adds hash steps hash1, hash2: the scan tests one window slot as load against
// every slot in parallel per cycle. Results sit in an output register, so the
// next item is taken while a result waits; its commit then waits until that
// result is taken. max_gap is to be written through cfg_we/cfg_wdata while the
// block is idle; the block does not enforce this. Its reset value is 4.
module load_mul_join_chain_detector
  import lmjcd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [GAP_W-1:0] cfg_wdata,
  lmjcd_in_if.sink         in_ch,
  lmjcd_out_if.source      out_ch
);

  lmjcd_cmd_t cmd;
  lmjcd_sts_t sts;

  lmjcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmjcd_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
